/* design/tefd_pkg.sv */
// ----------------------------------------------------------------------------
// tefd_pkg
// Shared constants, types and helpers for the tape echo fractional delay unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tefd_pkg;

  // Default ring depth in samples
  localparam int TEFD_RING_DEPTH = 65536;

  // Glide step numerator over 65536 (about 0.001 of the gap)
  localparam int GLIDE_NUM = 66;

  // Register reset values
  localparam logic        RST_ECHO_ENABLE   = 1'b0;
  localparam logic [15:0] RST_TARGET_DELAY  = 16'd14400;
  localparam logic [14:0] RST_FEEDBACK_GAIN = 15'd13107;
  localparam logic [14:0] RST_WET_MIX       = 15'd11469;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_ECHO_ENABLE   = 2'd0;
  localparam logic [1:0] REG_TARGET_DELAY  = 2'd1;
  localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd2;
  localparam logic [1:0] REG_WET_MIX       = 2'd3;

  // Configuration seen by the datapath
  typedef struct packed {
    logic        echo_enable;
    logic [15:0] target_delay;
    logic [14:0] feedback_gain;
    logic [14:0] wet_mix;
  } cfg_t;

  // Controller to datapath commands, at most one active per cycle
  typedef struct packed {
    logic load;
    logic step;
    logic rd_left;
    logic rd_right;
    logic interp;
    logic mul_a;
    logic mul_b;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_full;
  } sts_t;

  // Clamp a wide signed value to the 16-bit sample range
  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/tefd_if.sv */
// ----------------------------------------------------------------------------
// tefd_if
// Valid/ready sample channels: input beat and output beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tefd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dry_in;
  logic               block_end_in;

  modport source (output valid, output dry_in, output block_end_in, input ready);
  modport sink   (input valid, input dry_in, input block_end_in, output ready);
endinterface

interface tefd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_out;
  logic               block_end_out;

  modport source (output valid, output mixed_out, output block_end_out, input ready);
  modport sink   (input valid, input mixed_out, input block_end_out, output ready);
endinterface

`default_nettype wire

/* design/tefd_ram.sv */
// ----------------------------------------------------------------------------
// tefd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tefd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* design/tefd_regs.sv */
// ----------------------------------------------------------------------------
// tefd_regs
// APB-style configuration registers: enable, target delay, feedback, wet mix.
// ----------------------------------------------------------------------------
`default_nettype none

module tefd_regs
  import tefd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_enable   <= RST_ECHO_ENABLE;
      cfg.target_delay  <= RST_TARGET_DELAY;
      cfg.feedback_gain <= RST_FEEDBACK_GAIN;
      cfg.wet_mix       <= RST_WET_MIX;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_ECHO_ENABLE:   cfg.echo_enable   <= pwdata[0];
        REG_TARGET_DELAY:  cfg.target_delay  <= pwdata[15:0];
        REG_FEEDBACK_GAIN: cfg.feedback_gain <= pwdata[14:0];
        REG_WET_MIX:       cfg.wet_mix       <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_index)
      REG_ECHO_ENABLE:   prdata = 32'(cfg.echo_enable);
      REG_TARGET_DELAY:  prdata = 32'(cfg.target_delay);
      REG_FEEDBACK_GAIN: prdata = 32'(cfg.feedback_gain);
      REG_WET_MIX:       prdata = 32'(cfg.wet_mix);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/tefd_ctrl.sv */
// ----------------------------------------------------------------------------
// tefd_ctrl
// Sequencer: walks one sample through glide, two ring reads, interpolation,
// mixing and writeback.
// ----------------------------------------------------------------------------
`default_nettype none

module tefd_ctrl
  import tefd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_RDL    = 3'd2;
  localparam logic [2:0] S_RDR    = 3'd3;
  localparam logic [2:0] S_INTERP = 3'd4;
  localparam logic [2:0] S_MULA   = 3'd5;
  localparam logic [2:0] S_MULB   = 3'd6;
  localparam logic [2:0] S_WRITE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Decode commands
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.step     = (state == S_STEP);
    cmd.rd_left  = (state == S_RDL);
    cmd.rd_right = (state == S_RDR);
    cmd.interp   = (state == S_INTERP);
    cmd.mul_a    = (state == S_MULA);
    cmd.mul_b    = (state == S_MULB);
    cmd.commit   = (state == S_WRITE) && !sts.out_full;
  end

  // Advance; hold in writeback while the output register is full and not being taken
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) begin state_next = S_STEP; end
      S_STEP:   state_next = S_RDL;
      S_RDL:    state_next = S_RDR;
      S_RDR:    state_next = S_INTERP;
      S_INTERP: state_next = S_MULA;
      S_MULA:   state_next = S_MULB;
      S_MULB:   state_next = S_WRITE;
      S_WRITE:  if (!sts.out_full) begin state_next = S_IDLE; end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command active");
  a_load_step: assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.step)
    else $error("accepted beat not followed by glide step");
  a_step_read: assert property (@(posedge clk) disable iff (rst) cmd.step |=> cmd.rd_left)
    else $error("glide step not followed by left read");
`endif

endmodule

`default_nettype wire

/* design/tefd_datapath.sv */
// ----------------------------------------------------------------------------
// tefd_datapath
// Glide delay, ring addressing, interpolation, wet/dry mix, feedback
// writeback and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tefd_datapath
  import tefd_pkg::*;
#(
  parameter int RING_DEPTH = TEFD_RING_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic signed [15:0] dry_in,
  input  wire logic               block_end_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      mixed_out,
  output logic                    block_end_out
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + 16;
  localparam int EW = (PW + 1 > 33) ? PW + 1 : 33;
  localparam logic [EW-1:0] SPAN = EW'(RING_DEPTH) << 16;

  // Sample state
  logic [AW-1:0]      wi;
  logic               wrapped;
  logic [31:0]        glide;
  logic signed [15:0] dry;
  logic               block_end;
  logic [15:0]        frac;
  logic [AW-1:0]      right_addr;
  logic               valid_l;
  logic               valid_r;
  logic signed [15:0] sl;
  logic signed [15:0] wet;
  logic signed [33:0] pa;
  logic signed [31:0] pc;
  logic signed [31:0] pb;
  logic signed [15:0] mixed;

  // Ring port
  logic [AW-1:0]      rd_addr;
  logic [15:0]        rd_data;
  logic signed [15:0] back;

  // Effective gains
  logic [14:0] mix;
  logic [14:0] fb;
  assign mix = cfg.echo_enable ? cfg.wet_mix : '0;
  assign fb  = cfg.echo_enable ? cfg.feedback_gain : '0;

  // Clamp target and scale to 16.16
  logic [15:0] tgt_c;
  logic [31:0] tgt32;
  assign tgt_c = (32'(cfg.target_delay) >= 32'(RING_DEPTH - 1)) ?
                 16'(RING_DEPTH - 2) : cfg.target_delay;
  assign tgt32 = {tgt_c, 16'h0000};

  // Glide step: floor((target - glide) * 66 / 65536)
  logic signed [32:0] gdiff;
  logic signed [39:0] gprod;
  logic signed [39:0] gstep;
  assign gdiff = $signed({1'b0, tgt32}) - $signed({1'b0, glide});
  assign gprod = 40'(gdiff) * 40'(GLIDE_NUM);
  assign gstep = gprod >>> 16;

  // Read position behind the write pointer, wrapped into the ring span
  logic [EW-1:0] pdiff;
  logic [EW-1:0] pos;
  logic [AW-1:0] left_c;
  logic [AW-1:0] right_c;
  assign pdiff   = EW'({wi, 16'h0000}) - EW'(glide);
  assign pos     = pdiff[EW-1] ? (pdiff + SPAN) : pdiff;
  assign left_c  = pos[PW-1:16];
  assign right_c = (left_c == AW'(RING_DEPTH - 1)) ? '0 : (left_c + 1'b1);

  assign rd_addr = cmd.rd_left ? left_c : right_addr;

  // Interpolate between neighbors on the fraction
  logic signed [15:0] sr;
  logic signed [16:0] sdiff;
  logic signed [33:0] iprod;
  logic signed [16:0] wsum;
  assign sr    = valid_r ? $signed(rd_data) : 16'sh0000;
  assign sdiff = 17'(sr) - 17'(sl);
  assign iprod = 34'($signed({1'b0, frac})) * 34'(sdiff);
  assign wsum  = 17'(sl) + 17'(iprod >>> 16);

  // Dry share is one minus the wet share
  logic [16:0] dmix;
  assign dmix = 17'd32768 - 17'(mix);

  // Mix sum and feedback writeback value
  logic signed [34:0] msum;
  assign msum = 35'(pa) + 35'(pc);
  assign back = sat16(36'(dry) + 36'(pb >>> 15));

  tefd_ram #(
    .WIDTH (16),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (wi),
    .wr_data (back),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state: write pointer, wrap mark, glide delay
  always_ff @(posedge clk) begin
    if (rst) begin
      wi      <= '0;
      wrapped <= 1'b0;
      glide   <= '0;
    end else begin
      if (cmd.load && (glide == '0)) begin
        glide <= tgt32;
      end else if (cmd.step) begin
        glide <= glide + gstep[31:0];
      end
      if (cmd.commit) begin
        if (wi == AW'(RING_DEPTH - 1)) begin
          wi      <= '0;
          wrapped <= 1'b1;
        end else begin
          wi <= wi + 1'b1;
        end
      end
    end
  end

  // Payload pipeline; entries past the write pointer before the first wrap read as zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dry       <= dry_in;
      block_end <= block_end_in;
    end
    if (cmd.rd_left) begin
      frac       <= pos[15:0];
      right_addr <= right_c;
      valid_l    <= wrapped || (left_c < wi);
      valid_r    <= wrapped || (right_c < wi);
    end
    if (cmd.rd_right) begin
      sl <= valid_l ? $signed(rd_data) : 16'sh0000;
    end
    if (cmd.interp) begin
      wet <= wsum[15:0];
    end
    if (cmd.mul_a) begin
      pa <= 34'(dry) * 34'($signed({1'b0, dmix}));
      pc <= 32'(wet) * 32'($signed({1'b0, mix}));
    end
    if (cmd.mul_b) begin
      pb    <= 32'(wet) * 32'($signed({1'b0, fb}));
      mixed <= sat16(36'(msum >>> 15));
    end
  end

  // Output register: load on commit, drop on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mixed_out     <= mixed;
      block_end_out <= block_end;
    end
  end

  assign sts.out_full = out_valid && !out_ready;

`ifndef SYNTHESIS
  a_commit_out: assert property (@(posedge clk) disable iff (rst) cmd.commit |=> out_valid)
    else $error("committed sample not presented at output");
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_left |-> (32'(left_c) < 32'(RING_DEPTH)))
    else $error("read position outside the ring");
`endif

endmodule

`default_nettype wire

/* design/tape_echo_fractional_delay_unit.sv */
// Each accepted beat goes through the glide step, both ring reads, interpolation, the
// multiplies and writeback before the next is taken. The ring memory's single read port
// takes the two neighbor reads in turn, and the mix and feedback multiplies share steps.
// A full output register that is not taken holds writeback until the beat leaves.
// Reset: synchronous; the ring reads as zero until each entry is first written, by a
// write pointer and wrap mark, so there is no clearing pass and items are taken at once.
// ----------------------------------------------------------------------------
// tape_echo_fractional_delay_unit
// Feedback echo with a gliding fractional delay read by linear interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_echo_fractional_delay_unit
  import tefd_pkg::*;
#(
  parameter int RING_DEPTH = TEFD_RING_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  tefd_in_if.sink          in_ch,
  tefd_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  logic signed [15:0] mixed_out;
  logic block_end_out;

  tefd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tefd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tefd_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .dry_in        (in_ch.dry_in),
    .block_end_in  (in_ch.block_end_in),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .mixed_out     (mixed_out),
    .block_end_out (block_end_out)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.mixed_out     = mixed_out;
  assign out_ch.block_end_out = block_end_out;

endmodule

`default_nettype wire

/* tb/tb_tape_echo_fractional_delay_unit.sv */
// ----------------------------------------------------------------------------
// tb_tape_echo_fractional_delay_unit
// Self-checking bench for the tape echo: a table of directed samples and
// register writes, random phases under varied idle patterns and a clamped
// target run. A model of the ring, glide and mixer predicts untyped beats.
// ----------------------------------------------------------------------------

module tb_tape_echo_fractional_delay_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tefd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int TAIL_CYCLES    = 24;
  localparam int RAND_PHASES    = 7;
  localparam int PHASE_ITEMS    = 85;
  localparam int CLAMP_ITEMS    = 40;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    row_kind_e          kind;
    logic [1:0]         reg_idx;
    logic [15:0]        value;
    logic               block_end;
    logic               typed;
    logic signed [15:0] typed_mix;
  } vec_row_t;

  typedef struct {
    logic signed [15:0] mixed_out;
    logic               block_end_out;
  } mix_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tefd_in_if  in_bus ();
  tefd_out_if out_bus ();

  tape_echo_fractional_delay_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Echo model state and register shadow
  logic signed [15:0] echo_ring [TEFD_RING_DEPTH];
  logic [15:0]        wr_ptr;
  logic [31:0]        glide_fx;
  logic               cfg_echo_on;
  logic [15:0]        cfg_target;
  logic [14:0]        cfg_feedback;
  logic [14:0]        cfg_wet;

  mix_beat_t mix_expect_q[$];
  vec_row_t  vec_rows[$];
  int        err_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Advance the model by one sample and return the mixed output
  function automatic logic signed [15:0] echo_step(input logic signed [15:0] dry);
    logic [15:0] tgt_smp;
    logic [15:0] left_idx;
    logic [15:0] right_idx;
    logic [31:0] tgt_fx;
    logic [31:0] rd_pos;
    longint      d, gap, sl, sr, wet, m, fb, mixed, back;
    d = dry;
    // clamp the target two short of the ring depth
    tgt_smp = (int'(cfg_target) >= TEFD_RING_DEPTH - 1) ? 16'(TEFD_RING_DEPTH - 2) : cfg_target;
    tgt_fx = {tgt_smp, 16'h0000};
    // snap on first use, and again while the delay rests at zero
    if (glide_fx == '0) glide_fx = tgt_fx;
    gap = longint'(tgt_fx) - longint'(glide_fx);
    glide_fx = glide_fx + 32'((gap * GLIDE_NUM) >>> 16);
    // read behind the write pointer, wrapping on 16.16
    rd_pos = {wr_ptr, 16'h0000} - glide_fx;
    left_idx = rd_pos[31:16];
    right_idx = left_idx + 16'd1;
    sl = echo_ring[left_idx];
    sr = echo_ring[right_idx];
    wet = sl + ((longint'(rd_pos[15:0]) * (sr - sl)) >>> 16);
    m = cfg_echo_on ? longint'(cfg_wet) : 0;
    fb = cfg_echo_on ? longint'(cfg_feedback) : 0;
    mixed = (d * (32768 - m) + wet * m) >>> 15;
    back = d + ((wet * fb) >>> 15);
    echo_ring[wr_ptr] = clip16(back);
    wr_ptr = wr_ptr + 16'd1;
    return clip16(mixed);
  endfunction

  task automatic log_failure(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", what);
  endtask

  // Compare one output beat with the oldest prediction
  task automatic check_result(input logic signed [15:0] got_mix, input logic got_end);
    mix_beat_t want;
    if (mix_expect_q.size() == 0) begin
      log_failure($sformatf("unexpected result beat: mixed_out %0d block_end_out %0b",
                            got_mix, got_end));
    end else begin
      want = mix_expect_q.pop_front();
      if (got_mix !== want.mixed_out || got_end !== want.block_end_out) begin
        log_failure($sformatf("result mismatch: mixed_out exp %0d got %0d, block_end_out exp %0b got %0b",
                              want.mixed_out, got_mix, want.block_end_out, got_end));
      end
    end
  endtask

  // Write one register over the config port and update the shadow
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ECHO_ENABLE:   cfg_echo_on  = val[0];
      REG_TARGET_DELAY:  cfg_target   = val;
      REG_FEEDBACK_GAIN: cfg_feedback = val[14:0];
      REG_WET_MIX:       cfg_wet      = val[14:0];
      default: ;
    endcase
  endtask

  // Hold off the sender until every predicted beat has arrived
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (mix_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one sample beat; predict its result once it is taken
  task automatic send_sample(input logic [15:0] dry, input logic be,
                             input logic typed, input logic signed [15:0] typed_mix);
    mix_beat_t beat;
    logic signed [15:0] calc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.dry_in       <= dry;
    in_bus.block_end_in <= be;
    do @(posedge clk); while (!in_bus.ready);
    calc = echo_step($signed(dry));
    beat.mixed_out     = typed ? typed_mix : calc;
    beat.block_end_out = be;
    mix_expect_q.push_back(beat);
  endtask

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default:   begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  function automatic void add_write(input logic [1:0] idx, input logic [15:0] val);
    vec_row_t r;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.value = val;
    r.block_end = 1'b0;
    r.typed = 1'b0;
    r.typed_mix = '0;
    vec_rows.push_back(r);
  endfunction

  function automatic void add_sample(input logic [15:0] dry, input logic be,
                                     input logic typed, input logic signed [15:0] typed_mix);
    vec_row_t r;
    r.kind = ROW_SAMPLE;
    r.reg_idx = REG_ECHO_ENABLE;
    r.value = dry;
    r.block_end = be;
    r.typed = typed;
    r.typed_mix = typed_mix;
    vec_rows.push_back(r);
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [15:0] s;
    case ($urandom_range(9))
      0:       s = 16'h7FFF;
      1:       s = 16'h8000;
      2, 3:    s = 16'h0000;
      4, 5:    s = 16'($urandom_range(511)) - 16'd256;
      default: s = 16'($urandom());
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_gain();
    logic [15:0] g;
    case ($urandom_range(5))
      0:       g = 16'h0000;
      1:       g = 16'h7FFF;
      default: g = 16'($urandom_range(32767));
    endcase
    return g;
  endfunction

  // Take result beats and stall at random
  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) begin
      check_result(out_bus.mixed_out, out_bus.block_end_out);
    end
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int n_items;
    int pause_at;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.dry_in       <= '0;
    in_bus.block_end_in <= 1'b0;

    // model reset state
    foreach (echo_ring[i]) echo_ring[i] = '0;
    wr_ptr       = '0;
    glide_fx     = '0;
    cfg_echo_on  = RST_ECHO_ENABLE;
    cfg_target   = RST_TARGET_DELAY;
    cfg_feedback = RST_FEEDBACK_GAIN;
    cfg_wet      = RST_WET_MIX;

    // Directed rows: disabled pass-through at zero delay, full-scale mix and
    // feedback, writeback saturation both ways, then dry-only with echo on
    add_write(REG_TARGET_DELAY, 16'd0);
    add_sample(16'h8000, 1'b0, 1'b1, 16'sh8000);
    add_sample(16'h7FFF, 1'b1, 1'b1, 16'sh7FFF);
    add_sample(16'h0000, 1'b0, 1'b1, 16'sh0000);
    add_sample(16'hFFFF, 1'b1, 1'b1, -16'sd1);
    add_sample(16'h5555, 1'b0, 1'b1, 16'sh5555);
    add_sample(16'hAAAA, 1'b1, 1'b1, 16'shAAAA);
    add_write(REG_ECHO_ENABLE, 16'd1);
    add_write(REG_WET_MIX, 16'h7FFF);
    add_write(REG_FEEDBACK_GAIN, 16'h7FFF);
    add_sample(16'h7FFF, 1'b0, 1'b0, '0);
    add_sample(16'h8000, 1'b1, 1'b0, '0);
    add_write(REG_TARGET_DELAY, 16'd2);
    add_sample(16'h7FFF, 1'b0, 1'b0, '0);
    add_sample(16'h7FFF, 1'b0, 1'b0, '0);
    add_sample(16'h7FFF, 1'b1, 1'b0, '0);
    add_sample(16'h8000, 1'b0, 1'b0, '0);
    add_sample(16'h8000, 1'b0, 1'b0, '0);
    add_sample(16'h8000, 1'b1, 1'b0, '0);
    add_write(REG_WET_MIX, 16'd0);
    add_sample(16'h1234, 1'b0, 1'b1, 16'sh1234);
    add_sample(16'hEDCC, 1'b1, 1'b1, 16'shEDCC);
    add_sample(16'h0001, 1'b0, 1'b1, 16'sh0001);
    add_write(REG_FEEDBACK_GAIN, 16'd0);
    add_sample(16'h4000, 1'b0, 1'b0, '0);
    add_sample(16'hC000, 1'b1, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; write registers only once the pipe is empty
    foreach (vec_rows[i]) begin
      if (vec_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(vec_rows[i].reg_idx, vec_rows[i].value);
      end else begin
        send_sample(vec_rows[i].value, vec_rows[i].block_end,
                    vec_rows[i].typed, vec_rows[i].typed_mix);
      end
    end

    // Random phases with short delays so echoes come back within the run
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      write_reg(REG_ECHO_ENABLE, {15'd0, ($urandom_range(99) < 80) ? 1'b1 : 1'b0});
      write_reg(REG_TARGET_DELAY, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(48, 1)));
      write_reg(REG_FEEDBACK_GAIN, pick_gain());
      write_reg(REG_WET_MIX, pick_gain());
      set_idle_mode(idle_mode_e'(p % 4));
      n_items = PHASE_ITEMS;
      pause_at = $urandom_range(PHASE_ITEMS - 1);
      for (int k = 0; k < n_items; k++) begin
        if (k == pause_at) drain_results();
        send_sample(pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    // Drive the target past the ring limit so the clamp sets the glide
    drain_results();
    write_reg(REG_ECHO_ENABLE, 16'd1);
    write_reg(REG_TARGET_DELAY, 16'hFFFF);
    write_reg(REG_FEEDBACK_GAIN, pick_gain());
    write_reg(REG_WET_MIX, 16'h7FFF);
    set_idle_mode(IDLE_BOTH);
    for (int k = 0; k < CLAMP_ITEMS; k++) begin
      send_sample(pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
    end

    // Drop valid, collect the tail and report
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (mix_expect_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
design/tefd_pkg.sv
design/tefd_if.sv
design/tefd_ram.sv
design/tefd_regs.sv
design/tefd_ctrl.sv
design/tefd_datapath.sv
design/tape_echo_fractional_delay_unit.sv
tb/tb_tape_echo_fractional_delay_unit.sv
